### rtl/crfs_pkg.sv
// Shared types and constants for the card reader feed sequencer.
// No dependencies; crfs_csr, crfs_core, crfs_obuf and the top level import this package.
`default_nettype none

package crfs_pkg;

   // Deck and card geometry.
   localparam logic [10:0] DECK_CARDS   = 11'd1024;
   localparam logic [6:0]  CARD_COLUMNS = 7'd80;
   localparam logic [10:0] CURSOR_MAX   = 11'h7ff;

   // Reset values of the timeout registers and the nibble mask.
   localparam logic [15:0] CMD_TIMEOUT_RST   = 16'd12500;
   localparam logic [9:0]  FININ_TIMEOUT_RST = 10'd250;
   localparam logic [7:0]  NIBBLE_MASK       = 8'h0f;

   // Read modes.
   localparam logic [1:0] MODE_BINARY     = 2'd2;
   localparam logic [1:0] MODE_COL_BINARY = 2'd3;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      REG_DECK_PRESENT      = 3'd0,
      REG_REGISTERED_MODE   = 3'd1,
      REG_PACK_ALL          = 3'd2,
      REG_PACK_AFTER_LOADER = 3'd3,
      REG_LOADER_INDEX      = 3'd4,
      REG_CARD_TOTAL        = 3'd5,
      REG_COMMAND_TIMEOUT   = 3'd6,
      REG_FININ_TIMEOUT     = 3'd7
   } crfs_reg_index_type;

   // Feed machine states.
   typedef enum logic [4:0] {
      ST_ARMED     = 5'b00001,
      ST_PRESENT   = 5'b00010,
      ST_CARD_DONE = 5'b00100,
      ST_DONE      = 5'b01000,
      ST_ERROR     = 5'b10000
   } crfs_state_type;

   // Configuration register file contents.
   typedef struct packed {
      logic        deck_present;
      logic [1:0]  registered_mode;
      logic        pack_all;
      logic        pack_after_loader;
      logic [9:0]  loader_index;
      logic [10:0] card_total;
      logic [15:0] command_timeout;
      logic [9:0]  finin_timeout;
   } crfs_cfg_type;

   // Cursor preload that goes with a write of the loader index.
   typedef struct packed {
      logic       load;
      logic [9:0] index;
   } crfs_cursor_load_type;

   // One input item.
   typedef struct packed {
      logic       feed_strobe;
      logic       read_command;
      logic       card_reject;
      logic       out_of_service;
      logic       jam_error;
      logic       transfer_phase;
      logic       strobe_line;
      logic       cpu_mode_valid;
      logic [1:0] cpu_mode;
      logic [7:0] column_byte;
      logic [6:0] column_count;
   } crfs_req_type;

   // One result item.
   typedef struct packed {
      logic [7:0]  data_lines;
      logic        data_strobe;
      logic        end_of_card;
      logic        ready_res;
      logic        deck_end;
      logic        raw_read;
      logic        first_column;
      logic        low_nibble;
      logic [10:0] card_address;
      logic [6:0]  column_address;
      logic [1:0]  column_mode;
   } crfs_rsp_type;

endpackage

`default_nettype wire

### rtl/crfs_req_if.sv
// Input channel of the card reader feed sequencer: valid, ready and one event item.
// No dependencies.
`default_nettype none

interface crfs_req_if;
   logic       valid;
   logic       ready;
   logic       feed_strobe;
   logic       read_command;
   logic       card_reject;
   logic       out_of_service;
   logic       jam_error;
   logic       transfer_phase;
   logic       strobe_line;
   logic       cpu_mode_valid;
   logic [1:0] cpu_mode;
   logic [7:0] column_byte;
   logic [6:0] column_count;

   modport source (
      output valid, feed_strobe, read_command, card_reject, out_of_service, jam_error,
             transfer_phase, strobe_line, cpu_mode_valid, cpu_mode, column_byte,
             column_count,
      input  ready
   );

   modport sink (
      input  valid, feed_strobe, read_command, card_reject, out_of_service, jam_error,
             transfer_phase, strobe_line, cpu_mode_valid, cpu_mode, column_byte,
             column_count,
      output ready
   );
endinterface

`default_nettype wire

### rtl/crfs_rsp_if.sv
// Result channel of the card reader feed sequencer: valid, ready and one result item.
// No dependencies.
`default_nettype none

interface crfs_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  data_lines;
   logic        data_strobe;
   logic        end_of_card;
   logic        ready_res;
   logic        deck_end;
   logic        raw_read;
   logic        first_column;
   logic        low_nibble;
   logic [10:0] card_address;
   logic [6:0]  column_address;
   logic [1:0]  column_mode;

   modport source (
      output valid, data_lines, data_strobe, end_of_card, ready_res, deck_end, raw_read,
             first_column, low_nibble, card_address, column_address, column_mode,
      input  ready
   );

   modport sink (
      input  valid, data_lines, data_strobe, end_of_card, ready_res, deck_end, raw_read,
             first_column, low_nibble, card_address, column_address, column_mode,
      output ready
   );
endinterface

`default_nettype wire

### rtl/crfs_csr.sv
// Configuration registers of the card reader feed sequencer.
// Depends on crfs_pkg for the register indexes and the configuration struct.
`default_nettype none

module crfs_csr
   import crfs_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [2:0]           csr_index,
   input  wire logic [15:0]          csr_wdata,
   output crfs_cfg_type              cfg,
   output crfs_cursor_load_type      cursor_load
);

   crfs_cfg_type cfg_ff, cfg_in;

   // Register writes; every index of the port maps to a register.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (crfs_reg_index_type'(csr_index))
            REG_DECK_PRESENT:      cfg_in.deck_present      = csr_wdata[0];
            REG_REGISTERED_MODE:   cfg_in.registered_mode   = csr_wdata[1:0];
            REG_PACK_ALL:          cfg_in.pack_all          = csr_wdata[0];
            REG_PACK_AFTER_LOADER: cfg_in.pack_after_loader = csr_wdata[0];
            REG_LOADER_INDEX:      cfg_in.loader_index      = csr_wdata[9:0];
            REG_CARD_TOTAL:        cfg_in.card_total        = csr_wdata[10:0];
            REG_COMMAND_TIMEOUT:   cfg_in.command_timeout   = csr_wdata;
            REG_FININ_TIMEOUT:     cfg_in.finin_timeout     = csr_wdata[9:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.deck_present      <= 1'b0;
         cfg_ff.registered_mode   <= 2'd0;
         cfg_ff.pack_all          <= 1'b0;
         cfg_ff.pack_after_loader <= 1'b0;
         cfg_ff.loader_index      <= 10'd0;
         cfg_ff.card_total        <= 11'd0;
         cfg_ff.command_timeout   <= CMD_TIMEOUT_RST;
         cfg_ff.finin_timeout     <= FININ_TIMEOUT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // A loader index write also moves the card cursor to that card.
   assign cursor_load.load  = csr_we && (crfs_reg_index_type'(csr_index) == REG_LOADER_INDEX);
   assign cursor_load.index = csr_wdata[9:0];
   assign cfg = cfg_ff;

endmodule

`default_nettype wire

### rtl/crfs_core.sv
// Feed machine of the card reader feed sequencer: state registers and the
// combinational next-state logic. Depends on crfs_pkg.
`default_nettype none

module crfs_core
   import crfs_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire crfs_cfg_type         cfg,
   input  wire crfs_cursor_load_type cursor_load,
   input  wire logic                 accept,
   input  wire crfs_req_type         req,
   output crfs_rsp_type              rsp
);

   crfs_state_type st_ff, st_in;
   logic [10:0] cc_ff, cc_in;
   logic [6:0]  col_ff, col_in;
   logic        nh_ff, nh_in;
   logic        rp_ff, rp_in;
   logic        ep_ff, ep_in;
   logic        ca_ff, ca_in;
   logic [15:0] cw_ff, cw_in;
   logic [9:0]  fw_ff, fw_in;
   logic        ff_ff, ff_in;
   logic [7:0]  dr_ff, dr_in;
   logic        sr_ff, sr_in;
   logic        de_ff, de_in;
   logic        rr_ff, rr_in;
   logic        fc_ff, fc_in;
   logic        ln_ff, ln_in;

   logic [10:0]    total;
   logic [6:0]     ncols;
   logic [10:0]    cc_inc;
   crfs_state_type nc_st;
   logic [1:0]     out_mode;

   // Mode in which the card at the given cursor is transcoded.
   function automatic logic [1:0] eff_mode(input crfs_cfg_type c, input logic [10:0] cur,
                                           input logic mv, input logic [1:0] cm);
      logic [1:0] m;
      if (c.pack_all || (cur == {1'b0, c.loader_index})) begin
         m = c.registered_mode;
      end else if (c.pack_after_loader) begin
         m = MODE_COL_BINARY;
      end else if (mv) begin
         m = cm;
      end else begin
         m = MODE_BINARY;
      end
      return m;
   endfunction

   // Clamped deck size and column count.
   assign total = (cfg.card_total > DECK_CARDS) ? DECK_CARDS : cfg.card_total;
   assign ncols = (req.column_count > CARD_COLUMNS) ? CARD_COLUMNS : req.column_count;

   // The cursor moves at most once per item, so its successor is formed once.
   assign cc_inc = (cc_ff < CURSOR_MAX) ? (cc_ff + 11'd1) : cc_ff;
   assign nc_st  = (cc_inc >= total) ? ST_DONE : ST_ARMED;

   assign out_mode = eff_mode(cfg, cc_in, req.cpu_mode_valid, req.cpu_mode);

   // Next state for one item, in the order the machine cycle resolves it.
   always_comb begin
      logic done;
      logic trig;
      logic pk;
      logic tail_col;
      logic last;
      logic [7:0] val;

      st_in = st_ff;  cc_in = cc_ff;  col_in = col_ff; nh_in = nh_ff;
      rp_in = rp_ff;  ep_in = ep_ff;  ca_in = ca_ff;   cw_in = cw_ff;
      fw_in = fw_ff;  ff_in = ff_ff;  dr_in = dr_ff;   sr_in = sr_ff;
      de_in = de_ff;  rr_in = rr_ff;  fc_in = fc_ff;   ln_in = ln_ff;
      done = 1'b0;
      trig = 1'b0;
      pk = 1'b0;
      tail_col = 1'b0;
      last = 1'b0;
      val = 8'd0;

      if (req.out_of_service || req.jam_error) begin
         // Error lines freeze everything but the state and the command latch.
         st_in = ST_ERROR;
         ca_in = 1'b0;
         done = 1'b1;
      end else begin
         if (st_in == ST_ERROR) begin
            st_in = (cc_ff < total) ? ST_ARMED : ST_DONE;
         end

         // Reject releases the flag and skips an idle card.
         if (req.card_reject) begin
            ff_in = 1'b0; dr_in = 8'd0; fw_in = 10'd0;
            if ((st_in == ST_CARD_DONE) || (st_in == ST_ARMED)) begin
               col_in = 7'd0; nh_in = 1'b0; cc_in = cc_inc; st_in = nc_st;
            end
         end

         if (st_in == ST_DONE) begin
            de_in = 1'b1;
            ca_in = 1'b0;
            done = 1'b1;
         end
      end

      if (!done) begin
         // Latch a read command when the reader is idle.
         if (req.read_command && ((st_in == ST_ARMED) || (st_in == ST_CARD_DONE))) begin
            ff_in = 1'b0; dr_in = 8'd0; fw_in = 10'd0;
            ca_in = 1'b1;
            cw_in = cfg.command_timeout;
         end

         // Feed strobe or command timeout starts the card; a feed strobe with no command moves past a finished card.
         if (req.feed_strobe) begin
            if (ca_in) begin
               ff_in = 1'b0; dr_in = 8'd0; fw_in = 10'd0;
               trig = 1'b1;
            end else if (st_in == ST_CARD_DONE) begin
               ff_in = 1'b0; dr_in = 8'd0; fw_in = 10'd0;
               col_in = 7'd0; nh_in = 1'b0; cc_in = cc_inc; st_in = nc_st;
            end
         end else if (ca_in && (cw_in != 16'd0)) begin
            cw_in = cw_in - 16'd1;
            if (cw_in == 16'd0) begin
               ff_in = 1'b0; dr_in = 8'd0; fw_in = 10'd0;
               trig = 1'b1;
            end
         end

         if (trig) begin
            ca_in = 1'b0;
            cw_in = 16'd0;
            if (st_in == ST_CARD_DONE) begin
               col_in = 7'd0; nh_in = 1'b0; cc_in = cc_inc; st_in = nc_st;
            end
            if (st_in == ST_ARMED) begin
               rr_in = (eff_mode(cfg, cc_in, req.cpu_mode_valid, req.cpu_mode)
                        >= MODE_BINARY);
               st_in = ST_PRESENT;
            end
         end

         // End-of-card flag timeout.
         if (fw_in != 10'd0) begin
            fw_in = fw_in - 10'd1;
            if (fw_in == 10'd0) begin
               ff_in = 1'b0; dr_in = 8'd0; fw_in = 10'd0;
            end
         end

         if (st_in != ST_PRESENT) begin
            done = 1'b1;
         end
      end

      // Retire cycle that follows every presentation.
      if (!done && rp_in) begin
         rp_in = 1'b0;
         sr_in = 1'b0;
         if (ep_in) begin
            ep_in = 1'b0;
            st_in = ST_CARD_DONE;
            fw_in = cfg.finin_timeout;
         end
         done = 1'b1;
      end

      // The channel must be in transfer with the strobe line low.
      if (!done && (!req.transfer_phase || req.strobe_line)) begin
         done = 1'b1;
      end

      // Empty card, or cursor past the last column.
      if (!done && ((ncols == 7'd0) || (col_in >= ncols))) begin
         st_in = ST_DONE;
         done = 1'b1;
      end

      // Present one column or one nibble of it.
      if (!done) begin
         pk = cfg.pack_all || (cfg.pack_after_loader && (cc_in != {1'b0, cfg.loader_index}));
         tail_col = (col_in == (ncols - 7'd1));
         if (pk) begin
            val  = nh_in ? (req.column_byte & NIBBLE_MASK)
                         : ((req.column_byte >> 4) & NIBBLE_MASK);
            last = nh_in && tail_col;
         end else begin
            val  = req.column_byte;
            last = tail_col;
         end
         fc_in = (col_in == 7'd0);
         ln_in = pk && nh_in;
         dr_in = val;
         ff_in = last;
         sr_in = 1'b1;
         ep_in = last;
         rp_in = 1'b1;
         if (pk && !nh_in) begin
            nh_in = 1'b1;
         end else begin
            nh_in = 1'b0;
            if (!tail_col) begin
               col_in = col_in + 7'd1;
            end
         end
      end
   end

   // State update on each accepted item; a loader write presets the cursor and takes priority over the update.
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_ARMED;  cc_ff <= 11'd0;  col_ff <= 7'd0;  nh_ff <= 1'b0;
         rp_ff <= 1'b0;      ep_ff <= 1'b0;   ca_ff <= 1'b0;   cw_ff <= 16'd0;
         fw_ff <= 10'd0;     ff_ff <= 1'b0;   dr_ff <= 8'd0;   sr_ff <= 1'b0;
         de_ff <= 1'b0;      rr_ff <= 1'b0;   fc_ff <= 1'b0;   ln_ff <= 1'b0;
      end else if (cursor_load.load) begin
         cc_ff <= {1'b0, cursor_load.index};
      end else if (accept) begin
         st_ff <= st_in;  cc_ff <= cc_in;  col_ff <= col_in;  nh_ff <= nh_in;
         rp_ff <= rp_in;  ep_ff <= ep_in;  ca_ff <= ca_in;    cw_ff <= cw_in;
         fw_ff <= fw_in;  ff_ff <= ff_in;  dr_ff <= dr_in;    sr_ff <= sr_in;
         de_ff <= de_in;  rr_ff <= rr_in;  fc_ff <= fc_in;    ln_ff <= ln_in;
      end
   end

   // Result item, taken from the updated state.
   always_comb begin
      rsp.data_lines     = dr_in;
      rsp.data_strobe    = sr_in;
      rsp.end_of_card    = ff_in;
      rsp.ready_res      = cfg.deck_present && !ca_in && !ff_in &&
                           ((st_in == ST_ARMED) || (st_in == ST_CARD_DONE));
      rsp.deck_end       = de_in;
      rsp.raw_read       = rr_in;
      rsp.first_column   = fc_in;
      rsp.low_nibble     = ln_in;
      rsp.card_address   = cc_in;
      rsp.column_address = col_in;
      rsp.column_mode    = out_mode;
   end

endmodule

`default_nettype wire

### rtl/crfs_obuf.sv
// Two-entry output buffer (output register plus skid register) for result items.
// Depends on crfs_pkg for the result struct.
`default_nettype none

module crfs_obuf
   import crfs_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   push,
   input  wire crfs_rsp_type push_data,
   output logic        in_ready,
   output logic        out_valid,
   input  wire logic   out_ready,
   output crfs_rsp_type out_data
);

   logic         out_valid_ff, out_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   crfs_rsp_type out_data_ff, out_data_in;
   crfs_rsp_type skid_data_ff, skid_data_in;

   // The skid register only fills while the output register is stalled.
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_data_in  = push_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign in_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

`default_nettype wire

### rtl/card_reader_feed_sequencer_unit.sv
// Top level of the card reader feed sequencer.
// Depends on crfs_pkg, crfs_req_if, crfs_rsp_if, crfs_csr, crfs_core and crfs_obuf.
//
// Usage:
//   One event item per machine cycle enters on req_ch while it is ready; each
//   accepted item gives exactly one result item on rsp_ch, in order. The result
//   of an item is registered in the output buffer. One item is taken every
//   clock while req_ch.ready is high: the whole feed machine update for an
//   item is one pass of logic from the state registers to the output register.
//   The csr_ port writes one configuration register per cycle with csr_we;
//   the user must write only while no item is in flight (not enforced by the
//   block). Writing the loader index also moves the card cursor to that card.
//   Reset (synchronous, active high) returns the feed machine to armed with
//   the cursor at card zero, clears all flags and restores the register
//   defaults; there is no clearing pass, items are taken right after reset.
//   When the receiver stalls, one more item is taken into a skid register;
//   after that req_ch.ready drops until the waiting result is taken.
`default_nettype none

module card_reader_feed_sequencer_unit
   import crfs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   crfs_req_if.sink         req_ch,
   crfs_rsp_if.source       rsp_ch,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   crfs_cfg_type         cfg;
   crfs_cursor_load_type cursor_load;
   crfs_req_type         req;
   crfs_rsp_type         core_rsp;
   crfs_rsp_type         out_rsp;
   logic                 buf_ready;
   logic                 accept;

   // Gather the input item.
   assign req.feed_strobe    = req_ch.feed_strobe;
   assign req.read_command   = req_ch.read_command;
   assign req.card_reject    = req_ch.card_reject;
   assign req.out_of_service = req_ch.out_of_service;
   assign req.jam_error      = req_ch.jam_error;
   assign req.transfer_phase = req_ch.transfer_phase;
   assign req.strobe_line    = req_ch.strobe_line;
   assign req.cpu_mode_valid = req_ch.cpu_mode_valid;
   assign req.cpu_mode       = req_ch.cpu_mode;
   assign req.column_byte    = req_ch.column_byte;
   assign req.column_count   = req_ch.column_count;

   assign req_ch.ready = buf_ready;
   assign accept       = req_ch.valid && buf_ready;

   crfs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cfg         (cfg),
      .cursor_load (cursor_load)
   );

   crfs_core u_core (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .cursor_load (cursor_load),
      .accept      (accept),
      .req         (req),
      .rsp         (core_rsp)
   );

   crfs_obuf u_obuf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (core_rsp),
      .in_ready  (buf_ready),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_data  (out_rsp)
   );

   // Spread the result item over the channel.
   assign rsp_ch.data_lines     = out_rsp.data_lines;
   assign rsp_ch.data_strobe    = out_rsp.data_strobe;
   assign rsp_ch.end_of_card    = out_rsp.end_of_card;
   assign rsp_ch.ready_res      = out_rsp.ready_res;
   assign rsp_ch.deck_end       = out_rsp.deck_end;
   assign rsp_ch.raw_read       = out_rsp.raw_read;
   assign rsp_ch.first_column   = out_rsp.first_column;
   assign rsp_ch.low_nibble     = out_rsp.low_nibble;
   assign rsp_ch.card_address   = out_rsp.card_address;
   assign rsp_ch.column_address = out_rsp.column_address;
   assign rsp_ch.column_mode    = out_rsp.column_mode;

endmodule

`default_nettype wire

### rtl/crfs_checker.sv
// Port-level checks for the card reader feed sequencer, bound to the top level.
// Depends on the top level's ports only.
`default_nettype none

module crfs_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic [7:0] rsp_data_lines,
   input wire logic       rsp_end_of_card,
   input wire logic       rsp_ready_res,
   input wire logic       rsp_deck_end,
   input wire logic       rsp_low_nibble
);

   // The buffer is empty once reset is released.
   a_ready_after_reset: assert property (@(posedge clock)
      ($past(reset) && !reset) |-> req_ready)
      else $error("input not ready right after reset");

   // Input is only held off while a result waits in the output register.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked with no result pending");

   // A standing end-of-card flag keeps the reader busy.
   a_ready_vs_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_ready_res && rsp_end_of_card))
      else $error("ready shown while end-of-card flag stands");

   // A low nibble presentation carries only four data bits.
   a_low_nibble_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_low_nibble) |-> (rsp_data_lines[7:4] == 4'd0))
      else $error("low nibble presentation with upper data bits set");

   // Deck end stays set until reset.
   a_deck_end_sticky: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_deck_end) |=> (!rsp_valid || rsp_deck_end))
      else $error("deck end flag dropped");

endmodule

bind card_reader_feed_sequencer_unit crfs_checker u_crfs_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_data_lines  (rsp_ch.data_lines),
   .rsp_end_of_card (rsp_ch.end_of_card),
   .rsp_ready_res   (rsp_ch.ready_res),
   .rsp_deck_end    (rsp_ch.deck_end),
   .rsp_low_nibble  (rsp_ch.low_nibble)
);

`default_nettype wire
